// ----- sv/llhe_pkg.sv -----
`timescale 1ns / 1ps
package llhe_pkg;

	localparam int unsigned VALUE_W = 64;
	localparam int unsigned TALLY_W = 12;
	localparam int unsigned INDEX_W = 12;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_VALUE = 2'd2,
		CMD_RANK  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_NO_RANK   = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOC,
		S_READ,
		S_READ_DATA,
		S_ADD_READ,
		S_ADD_WRITE,
		S_WALK_GROUP,
		S_WALK_BUCKET,
		S_ARITH,
		S_FINISH,
		S_DONE
	} state_t;

	typedef enum logic {
		OP_FRAC,
		OP_MULSHIFT
	} arith_op_t;

endpackage

// ----- sv/log_linear_histogram_engine.sv -----
`timescale 1ns / 1ps
// Value and rank queries walk the group totals, then the bucket counts of
// one group, then interpolate one bit per cycle. One command is in work at
// a time. After reset a clearing pass zeroes the counter memories; no input
// transfer is taken until it ends.
module log_linear_histogram_engine #(
	parameter int unsigned GROUP_COUNT = 59,
	parameter int unsigned SUB_BUCKETS = 64,
	parameter int unsigned COUNTER_WIDTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [63:0] sample_value,
	input  logic [63:0] add_count,
	input  logic [63:0] query_rank,
	input  logic [11:0] bucket_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] bucket_low,
	output logic [63:0] bucket_high,
	output logic [63:0] bucket_hits,
	output logic [63:0] found_value,
	output logic [63:0] found_rank,
	output logic [63:0] population,
	output logic [11:0] occupied_buckets
);
	import llhe_pkg::*;

	localparam int unsigned CW = COUNTER_WIDTH;
	localparam int unsigned SBB = $clog2(SUB_BUCKETS);
	localparam int unsigned GW = $clog2(GROUP_COUNT);
	localparam int unsigned NB = GROUP_COUNT * SUB_BUCKETS;
	localparam int unsigned IW = $clog2(NB);
	localparam int unsigned WMAX = (GROUP_COUNT > SUB_BUCKETS) ? GROUP_COUNT : SUB_BUCKETS;
	localparam int unsigned WW = $clog2(WMAX + 1);

	state_t state_q, state_d;

	cmd_t          cmd_q;
	logic [63:0]   sval_q;
	logic [CW-1:0] acnt_q;
	logic [CW-1:0] rank_q;
	logic [GW-1:0] grp_q;
	logic [SBB-1:0] sub_q;
	logic          exact_q;
	logic [CW-1:0] pop_q;
	logic [TALLY_W-1:0] tally_q;
	logic [IW-1:0] clr_q;
	logic [WW-1:0] iss_q;
	logic [WW-1:0] lim_q;
	logic          dv_s1;
	logic [WW-1:0] idx_s1;

	status_t     stat_q;
	logic [63:0] low_q, high_q, hits_q, fval_q;

	logic        out_valid_q;
	status_t     out_status_q;
	logic [63:0] out_low_q, out_high_q, out_hits_q, out_fval_q, out_frank_q, out_pop_q;
	logic [TALLY_W-1:0] out_tally_q;

	logic accept;
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;

	// Memories
	logic          cnt_we, grp_we;
	logic [IW-1:0] cnt_addr;
	logic [GW-1:0] grp_addr;
	logic [CW-1:0] cnt_wdata, grp_wdata, cnt_rdata, grp_rdata;

	llhe_ram #(.WIDTH(CW), .DEPTH(NB)) u_cnt_ram (
		.clk(clk), .we(cnt_we), .addr(cnt_addr), .wdata(cnt_wdata), .rdata(cnt_rdata)
	);

	llhe_ram #(.WIDTH(CW), .DEPTH(GROUP_COUNT)) u_grp_ram (
		.clk(clk), .we(grp_we), .addr(grp_addr), .wdata(grp_wdata), .rdata(grp_rdata)
	);

	// Locate unit
	logic          loc_start, loc_done, loc_over;
	logic [GW-1:0] loc_grp;
	logic [SBB-1:0] loc_sub;

	assign loc_start = accept && ((cmd_t'(command) == CMD_RANK) ||
		((cmd_t'(command) == CMD_ADD) && (add_count[CW-1:0] != '0)));

	llhe_locate #(.GROUP_COUNT(GROUP_COUNT), .SUB_BUCKETS(SUB_BUCKETS)) u_locate (
		.clk(clk), .arst_n(arst_n), .start(loc_start), .value(sample_value),
		.done(loc_done), .grp(loc_grp), .sub(loc_sub), .over(loc_over)
	);

	// Bucket geometry of grp_q/sub_q
	logic [GW-1:0] ws;
	logic [63:0]   base, wmask;
	assign ws = (grp_q == '0) ? '0 : grp_q - GW'(1);
	assign base = (grp_q == '0) ? 64'(sub_q) : ((64'(SUB_BUCKETS) | 64'(sub_q)) << ws);
	assign wmask = ~((~64'd0) << ws);

	// Walk decisions
	logic [CW-1:0] walk_data;
	logic          walk_issue, walk_last, value_hit, rank_target, rank_mul;
	assign walk_data = (state_q == S_WALK_GROUP) ? grp_rdata : cnt_rdata;
	assign walk_issue = ((state_q == S_WALK_GROUP) || (state_q == S_WALK_BUCKET)) &&
		(iss_q < lim_q);
	assign walk_last = dv_s1 && (idx_s1 == lim_q - WW'(1));
	assign value_hit = dv_s1 && (walk_data != '0) && (rank_q <= walk_data);
	assign rank_target = dv_s1 && (idx_s1 == WW'(sub_q));
	assign rank_mul = (walk_data != '0) && (ws != '0);

	// Interpolation unit
	logic        arith_start, arith_done;
	arith_op_t   arith_op;
	logic [63:0] arith_result;

	assign arith_op = (cmd_q == CMD_VALUE) ? OP_FRAC : OP_MULSHIFT;
	assign arith_start = (state_q == S_WALK_BUCKET) &&
		(((cmd_q == CMD_VALUE) && value_hit && (rank_q != walk_data)) ||
		 ((cmd_q == CMD_RANK) && rank_target && rank_mul));

	llhe_arith #(.CW(CW), .KW(GW)) u_arith (
		.clk(clk), .arst_n(arst_n), .start(arith_start), .op(arith_op),
		.a(rank_q), .c(walk_data), .d(sval_q - base), .k(ws),
		.done(arith_done), .result(arith_result)
	);

	// Add datapath
	logic [CW-1:0] new_cnt;
	logic          was_occ, now_occ;
	assign new_cnt = cnt_rdata + acnt_q;
	assign was_occ = (cnt_rdata != '0);
	assign now_occ = (new_cnt != '0);

	// Value at rank: saturating sum of bucket base and interpolation
	logic [63:0] inter;
	logic [64:0] vsum;
	assign inter = exact_q ? (64'd1 << ws) : arith_result;
	assign vsum = {1'b0, base} + {1'b0, inter};

	logic read_bad;
	assign read_bad = (32'(bucket_index >> SBB) >= 32'(GROUP_COUNT));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == IW'(NB - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (accept) begin
					case (cmd_t'(command))
						CMD_ADD: state_d = (add_count[CW-1:0] == '0) ? S_DONE : S_LOC;
						CMD_READ: state_d = read_bad ? S_DONE : S_READ;
						CMD_VALUE: begin
							if (pop_q == '0 || query_rank > 64'(pop_q)) state_d = S_DONE;
							else state_d = S_WALK_GROUP;
						end
						default: state_d = S_LOC;
					endcase
				end
			end
			S_LOC: begin
				if (loc_done) begin
					if (cmd_q == CMD_ADD) state_d = S_ADD_READ;
					else if (loc_over) state_d = S_DONE;
					else if (loc_grp == '0) state_d = S_WALK_BUCKET;
					else state_d = S_WALK_GROUP;
				end
			end
			S_READ: state_d = S_READ_DATA;
			S_READ_DATA: state_d = S_DONE;
			S_ADD_READ: state_d = S_ADD_WRITE;
			S_ADD_WRITE: state_d = S_DONE;
			S_WALK_GROUP: begin
				if (cmd_q == CMD_VALUE) begin
					if (value_hit) state_d = S_WALK_BUCKET;
					else if (walk_last) state_d = S_DONE;
				end else if (walk_last) begin
					state_d = S_WALK_BUCKET;
				end
			end
			S_WALK_BUCKET: begin
				if (cmd_q == CMD_VALUE) begin
					if (value_hit) state_d = (rank_q == walk_data) ? S_FINISH : S_ARITH;
					else if (walk_last) state_d = S_DONE;
				end else if (rank_target) begin
					state_d = rank_mul ? S_ARITH : S_DONE;
				end
			end
			S_ARITH: begin
				if (arith_done) state_d = S_FINISH;
			end
			S_FINISH: state_d = S_DONE;
			S_DONE: begin
				if (!out_valid_q || !out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		cnt_we = 1'b0;
		grp_we = 1'b0;
		cnt_addr = {grp_q, sub_q};
		grp_addr = grp_q;
		cnt_wdata = '0;
		grp_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				cnt_we = 1'b1;
				cnt_addr = clr_q;
				grp_we = (clr_q < IW'(GROUP_COUNT));
				grp_addr = clr_q[GW-1:0];
			end
			S_ADD_WRITE: begin
				cnt_we = 1'b1;
				grp_we = 1'b1;
				cnt_wdata = new_cnt;
				grp_wdata = grp_rdata + acnt_q;
			end
			S_WALK_GROUP: grp_addr = iss_q[GW-1:0];
			S_WALK_BUCKET: cnt_addr = {grp_q, iss_q[SBB-1:0]};
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			pop_q <= '0;
			tally_q <= '0;
			iss_q <= '0;
			dv_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + IW'(1);
			if (state_q == S_ADD_WRITE) begin
				pop_q <= pop_q + acnt_q;
				if (now_occ && !was_occ) tally_q <= tally_q + TALLY_W'(1);
				else if (!now_occ && was_occ) tally_q <= tally_q - TALLY_W'(1);
			end
			if (state_d != state_q) begin
				// A new walk starts from entry zero with nothing in flight.
				iss_q <= '0;
				dv_s1 <= 1'b0;
			end else begin
				dv_s1 <= walk_issue;
				if (walk_issue) iss_q <= iss_q + WW'(1);
			end
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Work registers
	always_ff @(posedge clk) begin
		idx_s1 <= iss_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q <= cmd_t'(command);
					sval_q <= sample_value;
					acnt_q <= add_count[CW-1:0];
					rank_q <= query_rank[CW-1:0];
					grp_q <= GW'(bucket_index >> SBB);
					sub_q <= bucket_index[SBB-1:0];
					exact_q <= 1'b0;
					lim_q <= WW'(GROUP_COUNT);
					stat_q <= (cmd_t'(command) == CMD_VALUE) ? STAT_NO_RANK :
						((cmd_t'(command) == CMD_READ && read_bad) ? STAT_BAD_INDEX : STAT_OK);
					low_q <= '0;
					high_q <= '0;
					hits_q <= '0;
					fval_q <= '0;
				end
			end
			S_LOC: begin
				if (loc_done) begin
					grp_q <= loc_grp;
					sub_q <= loc_sub;
					rank_q <= loc_over ? pop_q : '0;
					lim_q <= (loc_grp == '0) ? WW'(loc_sub) + WW'(1) : WW'(loc_grp);
				end
			end
			S_READ_DATA: begin
				low_q <= base;
				high_q <= base | wmask;
				hits_q <= 64'(cnt_rdata);
			end
			S_WALK_GROUP: begin
				if (cmd_q == CMD_VALUE) begin
					if (value_hit) begin
						grp_q <= idx_s1[GW-1:0];
						lim_q <= WW'(SUB_BUCKETS);
					end else if (dv_s1) begin
						rank_q <= rank_q - walk_data;
					end
				end else if (dv_s1) begin
					rank_q <= rank_q + walk_data;
					if (walk_last) lim_q <= WW'(sub_q) + WW'(1);
				end
			end
			S_WALK_BUCKET: begin
				if (cmd_q == CMD_VALUE) begin
					if (value_hit) begin
						sub_q <= idx_s1[SBB-1:0];
						exact_q <= (rank_q == walk_data);
					end else if (dv_s1) begin
						rank_q <= rank_q - walk_data;
					end
				end else if (dv_s1 && !rank_target) begin
					rank_q <= rank_q + walk_data;
				end
			end
			S_FINISH: begin
				if (cmd_q == CMD_VALUE) begin
					stat_q <= STAT_OK;
					fval_q <= vsum[64] ? ~64'd0 : vsum[63:0];
				end else begin
					rank_q <= rank_q + arith_result[CW-1:0];
				end
			end
			default: ;
		endcase
	end

	// Output register
	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
			out_status_q <= stat_q;
			out_low_q <= low_q;
			out_high_q <= high_q;
			out_hits_q <= hits_q;
			out_fval_q <= fval_q;
			out_frank_q <= (cmd_q == CMD_RANK) ? 64'(rank_q) : 64'd0;
			out_pop_q <= 64'(pop_q);
			out_tally_q <= tally_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign bucket_low = out_low_q;
	assign bucket_high = out_high_q;
	assign bucket_hits = out_hits_q;
	assign found_value = out_fval_q;
	assign found_rank = out_frank_q;
	assign population = out_pop_q;
	assign occupied_buckets = out_tally_q;

`ifndef SYNTH
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_DONE)
		else $error("result appeared outside the completion state");

	a_tally_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tally_q <= TALLY_W'(NB))
		else $error("occupied tally exceeds the bucket count");

	a_walk_index: assert property (@(posedge clk) disable iff (!arst_n)
		dv_s1 |-> idx_s1 < lim_q)
		else $error("walk processed an entry past its limit");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("input taken during the clearing pass");
`endif

endmodule

// ----- sv/llhe_ram.sv -----
`timescale 1ns / 1ps
module llhe_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

// ----- sv/llhe_locate.sv -----
`timescale 1ns / 1ps
module llhe_locate #(
	parameter int unsigned GROUP_COUNT = 59,
	parameter int unsigned SUB_BUCKETS = 64,
	localparam int unsigned GW = $clog2(GROUP_COUNT),
	localparam int unsigned SBB = $clog2(SUB_BUCKETS)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   value,
	output logic          done,
	output logic [GW-1:0] grp,
	output logic [SBB-1:0] sub,
	output logic          over
);
	import llhe_pkg::*;

	// First stage finds the top set bit of each byte, second stage picks the top byte.
	logic        v_s1;
	logic [63:0] value_s1;
	logic [7:0]  nz_s1;
	logic [2:0]  pos_s1 [8];
	logic        small_s1;

	logic [7:0]  nz_c;
	logic [2:0]  pos_c [8];

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			nz_c[b] = |value[8*b +: 8];
			pos_c[b] = 3'd0;
			for (int p = 0; p < 8; p++) begin
				if (value[8*b + p]) begin
					pos_c[b] = 3'(p);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		value_s1 <= value;
		nz_s1 <= nz_c;
		small_s1 <= ((value >> SBB) == 64'd0);
		for (int b = 0; b < 8; b++) begin
			pos_s1[b] <= pos_c[b];
		end
	end

	logic [5:0] msb;
	logic [6:0] g7;
	logic [5:0] shamt;
	logic [63:0] shifted;

	always_comb begin
		msb = 6'd0;
		for (int b = 0; b < 8; b++) begin
			if (nz_s1[b]) begin
				msb = {3'(b), pos_s1[b]};
			end
		end
		g7 = 7'(msb) + 7'd1 - 7'(SBB);
		shamt = 6'(g7 - 7'd1);
		shifted = value_s1 >> shamt;
	end

	logic          done_s2;
	logic [GW-1:0] grp_s2;
	logic [SBB-1:0] sub_s2;
	logic          over_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			done_s2 <= 1'b0;
		end else begin
			v_s1 <= start;
			done_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (small_s1) begin
			grp_s2 <= '0;
			sub_s2 <= value_s1[SBB-1:0];
			over_s2 <= 1'b0;
		end else if (g7 >= 7'(GROUP_COUNT)) begin
			grp_s2 <= GW'(GROUP_COUNT - 1);
			sub_s2 <= SBB'(SUB_BUCKETS - 1);
			over_s2 <= 1'b1;
		end else begin
			grp_s2 <= g7[GW-1:0];
			sub_s2 <= shifted[SBB-1:0];
			over_s2 <= 1'b0;
		end
	end

	assign done = done_s2;
	assign grp = grp_s2;
	assign sub = sub_s2;
	assign over = over_s2;

endmodule

// ----- sv/llhe_arith.sv -----
`timescale 1ns / 1ps
module llhe_arith #(
	parameter int unsigned CW = 64,
	parameter int unsigned KW = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  llhe_pkg::arith_op_t  op,
	input  logic [CW-1:0]        a,
	input  logic [CW-1:0]        c,
	input  logic [63:0]          d,
	input  logic [KW-1:0]        k,
	output logic                 done,
	output logic [63:0]          result
);
	import llhe_pkg::*;

	// One bit per cycle. The fraction step keeps a remainder below the count;
	// the multiply step adds the count under each bit of d and halves.
	logic          busy_q;
	logic [KW-1:0] step_q;
	arith_op_t     op_q;
	logic [CW-1:0] c_q;
	logic [CW-1:0] rem_q;
	logic [63:0]   bits_q;

	logic [CW-1:0] diff;
	logic [CW:0]   sum;

	assign diff = c_q - rem_q;
	assign sum = {1'b0, rem_q} + (bits_q[0] ? {1'b0, c_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= k;
		end else if (busy_q) begin
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= step_q - KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q <= op;
			c_q <= c;
			if (op == OP_FRAC) begin
				rem_q <= a;
				bits_q <= '0;
			end else begin
				rem_q <= '0;
				bits_q <= d;
			end
		end else if (busy_q && step_q != '0) begin
			if (op_q == OP_FRAC) begin
				if (rem_q >= diff) begin
					rem_q <= rem_q - diff;
					bits_q <= {bits_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_q << 1;
					bits_q <= {bits_q[62:0], 1'b0};
				end
			end else begin
				rem_q <= sum[CW:1];
				bits_q <= bits_q >> 1;
			end
		end
	end

	assign done = busy_q && (step_q == '0);
	assign result = (op_q == OP_FRAC) ? bits_q : 64'(rem_q);

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import llhe_pkg::*;

	localparam int GROUPS = 59;
	localparam int SUBS = 64;
	localparam int NBKT = GROUPS * SUBS;
	localparam longint CYCLE_LIMIT = 3000000;

	typedef struct {
		cmd_t        cmd;
		logic [63:0] sval;
		logic [63:0] cnt;
		logic [63:0] rnk;
		logic [11:0] idx;
	} hist_cmd_t;

	typedef struct {
		status_t     st;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] hits;
		logic [63:0] fval;
		logic [63:0] frank;
		logic [63:0] pop;
		logic [11:0] occ;
	} hist_resp_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] command = 0;
	logic [63:0] sample_value = 0, add_count = 0, query_rank = 0;
	logic [11:0] bucket_index = 0;
	logic out_valid;
	logic out_stall = 0;
	logic [1:0] status;
	logic [63:0] bucket_low, bucket_high, bucket_hits, found_value, found_rank, population;
	logic [11:0] occupied_buckets;

	log_linear_histogram_engine dut (.*);

	always #4 clk = ~clk;

	// Predictor state.
	logic [63:0] counts[NBKT];
	logic [63:0] gtotal[GROUPS];
	logic [63:0] pop_sum;
	logic [11:0] occ_num;

	hist_cmd_t  pending_cmds[$];
	hist_resp_t expected_resps[$];
	int errors = 0;
	int mismatches = 0;
	longint cycles = 0;
	bit feed_done = 0;
	bit hold_sender = 0;
	int long_hold = 0;
	int burst_left = 0, gap_left = 0;

	function automatic int msb_of(logic [63:0] v);
		int p;
		p = 0;
		for (int i = 0; i < 64; i++)
			if (v[i]) p = i;
		return p;
	endfunction

	function automatic void find_bucket(logic [63:0] v, output int g, output int m);
		if (v < SUBS) begin
			g = 0;
			m = int'(v);
		end else begin
			g = msb_of(v) - 5;
			if (g >= GROUPS) begin
				g = GROUPS - 1;
				m = SUBS - 1;
			end else begin
				m = int'((v >> (g - 1)) & (SUBS - 1));
			end
		end
	endfunction

	function automatic logic [63:0] low_edge(int g, int m);
		if (g == 0) return 64'(m);
		return (64'(SUBS) | 64'(m)) << (g - 1);
	endfunction

	function automatic hist_resp_t histogram_predict(hist_cmd_t c);
		hist_resp_t r;
		int g, m, k, i;
		logic [63:0] rr, t, b, v, inter;
		logic [127:0] prod;
		bit found;
		r = '{STAT_OK, 0, 0, 0, 0, 0, 0, 0};
		case (c.cmd)
			CMD_ADD: begin
				if (c.cnt != 0) begin
					find_bucket(c.sval, g, m);
					i = g * SUBS + m;
					t = counts[i];
					counts[i] = t + c.cnt;
					gtotal[g] = gtotal[g] + c.cnt;
					pop_sum = pop_sum + c.cnt;
					if (t == 0 && counts[i] != 0) occ_num++;
					if (t != 0 && counts[i] == 0) occ_num--;
				end
			end
			CMD_READ: begin
				g = c.idx / SUBS;
				m = c.idx % SUBS;
				if (g >= GROUPS) begin
					r.st = STAT_BAD_INDEX;
				end else begin
					r.lo = low_edge(g, m);
					r.hi = r.lo + ((64'd1 << (g == 0 ? 0 : g - 1)) - 1);
					r.hits = counts[g * SUBS + m];
				end
			end
			CMD_VALUE: begin
				rr = c.rnk;
				found = 0;
				r.st = STAT_NO_RANK;
				g = GROUPS;
				m = 0;
				if (pop_sum != 0 && rr <= pop_sum) begin
					for (g = 0; g < GROUPS; g++) begin
						if (gtotal[g] == 0) continue;
						if (rr <= gtotal[g]) break;
						rr -= gtotal[g];
					end
					if (g < GROUPS) begin
						for (m = 0; m < SUBS; m++) begin
							t = counts[g * SUBS + m];
							if (t == 0) continue;
							if (rr <= t) begin
								found = 1;
								break;
							end
							rr -= t;
						end
					end
				end
				if (found) begin
					t = counts[g * SUBS + m];
					k = (g == 0) ? 0 : g - 1;
					if (rr == t) begin
						inter = 64'd1 << k;
					end else begin
						// Floor of rr * 2^k / t, with rr below t.
						prod = {64'd0, rr} << k;
						inter = prod / t;
					end
					b = low_edge(g, m);
					v = b + inter;
					if (v < b) v = '1;
					r.st = STAT_OK;
					r.fval = v;
				end
			end
			CMD_RANK: begin
				if (c.sval >= SUBS && msb_of(c.sval) - 5 >= GROUPS) begin
					r.frank = pop_sum;
				end else begin
					find_bucket(c.sval, g, m);
					v = 0;
					for (int e = 0; e < g; e++) v += gtotal[e];
					for (int p = 0; p < m; p++) v += counts[g * SUBS + p];
					t = counts[g * SUBS + m];
					k = (g == 0) ? 0 : g - 1;
					if (t != 0 && k != 0) begin
						prod = 128'(t) * 128'(c.sval - low_edge(g, m));
						v += 64'(prod >> k);
					end
					r.frank = v;
				end
			end
		endcase
		r.pop = pop_sum;
		r.occ = occ_num;
		return r;
	endfunction

	// Driver: bursts with random gaps.
	always @(posedge clk) begin
		hist_cmd_t c;
		if (arst_n) begin
			if (!(in_valid && in_stall)) begin
				if (in_valid) begin
					expected_resps.push_back(histogram_predict(pending_cmds.pop_front()));
				end
				if (gap_left > 0) gap_left--;
				if (pending_cmds.size() != 0 && gap_left == 0 && !hold_sender) begin
					c = pending_cmds[0];
					in_valid <= 1;
					command <= c.cmd;
					sample_value <= c.sval;
					add_count <= c.cnt;
					query_rank <= c.rnk;
					bucket_index <= c.idx;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 12);
						if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// Receiver stall pattern, with one long hold-off.
	always @(posedge clk) begin
		if (long_hold > 0) begin
			long_hold--;
			out_stall <= 1;
		end else if (cycles > 4000 && cycles < 4010) begin
			long_hold = 2000;
			out_stall <= 1;
		end else begin
			out_stall <= ((cycles / 300) % 3 == 0) ? 1'b0 : ($urandom_range(0, 3) == 0);
		end
	end

	// Monitor.
	always @(posedge clk) begin
		hist_resp_t e;
		cycles++;
		if (out_valid && !out_stall && arst_n) begin
			if (expected_resps.size() == 0) begin
				errors++;
				if (mismatches++ < 10) $display("unexpected result transfer");
			end else begin
				e = expected_resps.pop_front();
				if (status !== e.st || bucket_low !== e.lo || bucket_high !== e.hi ||
				    bucket_hits !== e.hits || found_value !== e.fval ||
				    found_rank !== e.frank || population !== e.pop ||
				    occupied_buckets !== e.occ) begin
					errors++;
					if (mismatches++ < 10)
						$display("mismatch: exp st=%0d lo=%h hi=%h hits=%h fv=%h fr=%h pop=%h occ=%0d got st=%0d lo=%h hi=%h hits=%h fv=%h fr=%h pop=%h occ=%0d",
							e.st, e.lo, e.hi, e.hits, e.fval, e.frank, e.pop, e.occ,
							status, bucket_low, bucket_high, bucket_hits, found_value,
							found_rank, population, occupied_buckets);
				end
			end
		end
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [63:0] rand_value();
		int s;
		s = $urandom_range(0, 63);
		return rand64() >> s;
	endfunction

	task automatic queue_cmd(cmd_t c, logic [63:0] sv, logic [63:0] cn, logic [63:0] rk,
	                         logic [11:0] ix);
		pending_cmds.push_back('{c, sv, cn, rk, ix});
	endtask

	initial begin
		logic [63:0] big;
		for (int i = 0; i < NBKT; i++) counts[i] = 0;
		for (int g = 0; g < GROUPS; g++) gtotal[g] = 0;
		pop_sum = 0;
		occ_num = 0;
		big = '1;
		// Directed: empty queries, extremes, zero count, wrap, bad index.
		queue_cmd(CMD_VALUE, 0, 0, 0, 0);
		queue_cmd(CMD_RANK, big, 0, 0, 0);
		queue_cmd(CMD_ADD, 5, 0, 0, 0);
		queue_cmd(CMD_ADD, 0, 3, 0, 0);
		queue_cmd(CMD_ADD, 63, 1, 0, 0);
		queue_cmd(CMD_ADD, 64, 2, 0, 0);
		queue_cmd(CMD_ADD, 127, 4, 0, 0);
		queue_cmd(CMD_ADD, big, 7, 0, 0);
		queue_cmd(CMD_READ, 0, 0, 0, 12'd0);
		queue_cmd(CMD_READ, 0, 0, 0, 12'd3775);
		queue_cmd(CMD_READ, 0, 0, 0, 12'd3776);
		queue_cmd(CMD_READ, 0, 0, 0, 12'hFFF);
		queue_cmd(CMD_VALUE, 0, 0, 0, 0);
		queue_cmd(CMD_VALUE, 0, 0, 5, 0);
		queue_cmd(CMD_VALUE, 0, 0, 17, 0);
		queue_cmd(CMD_VALUE, 0, 0, 18, 0);
		queue_cmd(CMD_VALUE, 0, 0, big, 0);
		queue_cmd(CMD_RANK, 100, 0, 0, 0);
		queue_cmd(CMD_RANK, big - 5, 0, 0, 0);
		queue_cmd(CMD_ADD, 64, big - 1, 0, 0);
		queue_cmd(CMD_READ, 0, 0, 0, 12'd64);
		queue_cmd(CMD_ADD, 65, big, 0, 0);
		queue_cmd(CMD_VALUE, 0, 0, 3, 0);
		for (int n = 0; n < 1930; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: queue_cmd(CMD_ADD, rand_value(),
					($urandom_range(0, 19) == 0) ? rand64() : 64'($urandom_range(0, 50)), 0, 0);
				4, 5: queue_cmd(CMD_READ, 0, 0, 0, 12'($urandom));
				6, 7: queue_cmd(CMD_VALUE, 0, 0,
					($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 3000)), 0);
				default: queue_cmd(CMD_RANK, rand_value(), 0, 0, 0);
			endcase
			if (n == 1000) begin
				// Sender pause until the block has drained.
				wait (pending_cmds.size() == 0 && !in_valid);
				hold_sender = 1;
				wait (expected_resps.size() == 0);
				hold_sender = 0;
			end
		end
		feed_done = 1;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		wait (feed_done && pending_cmds.size() == 0 && !in_valid);
		wait (expected_resps.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_resps.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule

// ----- sim.f -----
sv/llhe_pkg.sv
sv/llhe_ram.sv
sv/llhe_locate.sv
sv/llhe_arith.sv
sv/log_linear_histogram_engine.sv
bench/tb_top.sv
